// ===== hdl/insertion_sort_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Insertion sort engine assertion macros
// Concurrent assertion wrappers shared by the engine's modules.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORT_ENGINE_MACROS_SVH
`define INSERTION_SORT_ENGINE_MACROS_SVH

// Invariant that must hold at every clock edge out of reset
`define ISE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define ISE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ISE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion sort package
// Sizes, types and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

	localparam int DATA_W = 32;
	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Read address source for the store
	typedef enum logic [1:0] {
		RD_FILL_M1,
		RD_POS_M2,
		RD_K
	} rd_src_t;

	typedef struct packed {
		logic    load_in;
		logic    set_ovf;
		logic    wr_shift;
		logic    wr_place;
		logic    out_load;
		logic    clr_run;
		rd_src_t rd_src;
	} cmd_t;

	typedef struct packed {
		logic gt;
		logic full;
		logic fill_zero;
		logic pos_one;
		logic last;
		logic eor;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/isort_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one value and its end-of-run mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface isort_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [isort_pkg::DATA_W-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/isort_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one sorted value with run flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface isort_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [isort_pkg::DATA_W-1:0] sorted_value;
	logic                             end_of_run;
	logic                             dropped;

	modport source (output valid, output sorted_value, output end_of_run,
		output dropped, input ready);
	modport sink   (input valid, input sorted_value, input end_of_run,
		input dropped, output ready);
endinterface

`default_nettype wire

// ===== hdl/isort_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/isort_dp.sv =====
// ----------------------------------------------------------------------------
// Insertion sort datapath
// Sorted store, insertion pointer, fill count, readout index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "insertion_sort_engine_macros.svh"

module isort_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [isort_pkg::DATA_W-1:0] value,
	input  wire logic                                last,
	input  wire isort_pkg::cmd_t                     cmd,
	output      isort_pkg::sts_t                     sts,
	output      logic signed [isort_pkg::DATA_W-1:0] sorted_value,
	output      logic                                end_of_run,
	output      logic                                dropped
);

	logic signed [isort_pkg::DATA_W-1:0] val_q;
	logic                                last_q;
	isort_pkg::cnt_t                     pos_q;
	isort_pkg::cnt_t                     fill_q;
	isort_pkg::cnt_t                     k_q;
	logic                                ovf_q;
	logic signed [isort_pkg::DATA_W-1:0] sorted_value_q;
	logic                                end_of_run_q;
	logic                                dropped_q;

	isort_pkg::cnt_t                     rd_cnt;
	isort_pkg::addr_t                    rd_addr;
	logic [isort_pkg::DATA_W-1:0]        rd_data;
	logic                                wr_en;
	logic [isort_pkg::DATA_W-1:0]        wr_data;

	isort_ram #(
		.WIDTH (isort_pkg::DATA_W),
		.DEPTH (isort_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_q[isort_pkg::ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		case (cmd.rd_src)
			isort_pkg::RD_FILL_M1: rd_cnt = fill_q - isort_pkg::cnt_t'(1);
			isort_pkg::RD_POS_M2:  rd_cnt = pos_q - isort_pkg::cnt_t'(2);
			isort_pkg::RD_K:       rd_cnt = k_q;
			default:               rd_cnt = k_q;
		endcase
	end

	assign rd_addr = rd_cnt[isort_pkg::ADDR_W-1:0];

	// A shift moves the entry below the pointer up; a place drops the new value in
	assign wr_en   = cmd.wr_shift | cmd.wr_place;
	assign wr_data = cmd.wr_shift ? rd_data : val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			k_q    <= '0;
		end else begin
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.wr_place) begin
				fill_q <= fill_q + isort_pkg::cnt_t'(1);
			end
			if (cmd.out_load) begin
				k_q <= k_q + isort_pkg::cnt_t'(1);
			end
			if (cmd.clr_run) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				k_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			val_q  <= value;
			last_q <= last;
			pos_q  <= fill_q;
		end else if (cmd.wr_shift) begin
			pos_q <= pos_q - isort_pkg::cnt_t'(1);
		end
		if (cmd.out_load) begin
			sorted_value_q <= $signed(rd_data);
			end_of_run_q   <= (k_q + isort_pkg::cnt_t'(1)) == fill_q;
			dropped_q      <= ovf_q;
		end
	end

	always_comb begin
		sts.gt        = $signed(rd_data) > val_q;
		sts.full      = fill_q == isort_pkg::cnt_t'(isort_pkg::DEPTH);
		sts.fill_zero = fill_q == '0;
		sts.pos_one   = pos_q == isort_pkg::cnt_t'(1);
		sts.last      = last_q;
		sts.eor       = end_of_run_q;
	end

	assign sorted_value = sorted_value_q;
	assign end_of_run   = end_of_run_q;
	assign dropped      = dropped_q;

	`ISE_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= isort_pkg::cnt_t'(isort_pkg::DEPTH), "fill count beyond depth")
	`ISE_ASSERT_NXT(a_fill_step, clk, arst_n, cmd.wr_place, fill_q == $past(fill_q) + isort_pkg::cnt_t'(1), "placement did not advance fill count")
	`ISE_ASSERT_IMP(a_read_in_range, clk, arst_n, cmd.out_load, k_q < fill_q, "readout index past fill count")

endmodule

`default_nettype wire

// ===== hdl/isort_ctrl.sv =====
// ----------------------------------------------------------------------------
// Insertion sort controller
// Sequences acceptance, shift-down insertion and ordered readout of a run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "insertion_sort_engine_macros.svh"

module isort_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_last,
	output      logic            in_ready,
	output      logic            out_valid,
	input  wire logic            out_ready,
	input  wire isort_pkg::sts_t sts,
	output      isort_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_COMPARE,
		S_PLACE,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_WAIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.rd_src = isort_pkg::RD_K;
		case (state_q)
			S_IDLE: begin
				// Fetch the top entry so the first compare is ready next cycle
				cmd.rd_src = isort_pkg::RD_FILL_M1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.set_ovf = sts.full;
				end
			end
			S_COMPARE: begin
				if (sts.gt) begin
					cmd.wr_shift = 1'b1;
					cmd.rd_src   = isort_pkg::RD_POS_M2;
				end else begin
					cmd.wr_place = 1'b1;
				end
			end
			S_PLACE: begin
				cmd.wr_place = 1'b1;
			end
			S_OUT_RD: begin
				cmd.rd_src = isort_pkg::RD_K;
			end
			S_OUT_LD: begin
				cmd.out_load = 1'b1;
			end
			S_OUT_WAIT: begin
				cmd.rd_src  = isort_pkg::RD_K;
				cmd.clr_run = out_ready & sts.eor;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (sts.full) begin
							// drop the value; a last item still releases the run
							state_q <= in_last ? S_OUT_RD : S_IDLE;
						end else if (sts.fill_zero) begin
							state_q <= S_PLACE;
						end else begin
							state_q <= S_COMPARE;
						end
					end
				end
				S_COMPARE: begin
					if (sts.gt) begin
						if (sts.pos_one) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= sts.last ? S_OUT_RD : S_IDLE;
					end
				end
				S_PLACE: begin
					state_q <= sts.last ? S_OUT_RD : S_IDLE;
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LD;
				end
				S_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= sts.eor ? S_IDLE : S_OUT_LD;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	`ISE_ASSERT_ALWAYS(a_one_side_open, clk, arst_n, !(in_ready && out_valid_q), "input open while a result is pending")
	`ISE_ASSERT_IMP(a_valid_in_wait, clk, arst_n, out_valid_q, state_q == S_OUT_WAIT, "result valid outside the wait state")
	`ISE_ASSERT_NXT(a_final_returns, clk, arst_n, cmd.clr_run, in_ready && !out_valid_q, "run end did not return to idle")

endmodule

`default_nettype wire

// ===== hdl/insertion_sort_engine.sv =====
// ----------------------------------------------------------------------------
// Insertion sort engine: an item shifts each larger stored entry up, then is placed in the gap.
// A dropped item (store full) is accepted but not stored; the store is one RAM port read, one written a cycle.
// Readout: each result is loaded into the result register and held valid until it is taken.
// Reset clears the fill count, overflow flag and controller; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine (
	input  wire logic    clk,
	input  wire logic    arst_n,
	isort_in_if.sink     items,
	isort_out_if.source  results
);

	isort_pkg::cmd_t cmd;
	isort_pkg::sts_t sts;

	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	isort_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (items.value),
		.last         (items.last),
		.cmd          (cmd),
		.sts          (sts),
		.sorted_value (results.sorted_value),
		.end_of_run   (results.end_of_run),
		.dropped      (results.dropped)
	);

endmodule

`default_nettype wire
